### src/mhpq_pkg.sv
// types and codes shared by the min-heap priority queue
// no dependencies; used by the compare unit, the top level and the checker
package mhpq_pkg;

    localparam int KEY_W   = 32;
    localparam int TAG_W   = 16;
    localparam int CNT_OUT = 11;

    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] new_key;
        logic [TAG_W-1:0] new_tag;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [KEY_W-1:0]   min_key;
        logic [TAG_W-1:0]   min_tag;
        logic [CNT_OUT-1:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    // compare unit request and verdict
    typedef struct packed {
        logic             sift_down;
        logic             right_ok;
        logic [KEY_W-1:0] e_key;
        logic [KEY_W-1:0] a_key;
        logic [KEY_W-1:0] b_key;
    } t_cmp_req;

    typedef struct packed {
        logic pick_right;
        logic move;
    } t_cmp_res;

endpackage

### src/mhpq_cmp.sv
// shared key compare unit for one sift step, up or down
// depends on mhpq_pkg
module mhpq_cmp (
    input  mhpq_pkg::t_cmp_req i_req,
    output mhpq_pkg::t_cmp_res o_res
);
    import mhpq_pkg::*;

    logic [KEY_W-1:0] pick_key;
    logic             pick_right;

    always_comb begin
        pick_right = i_req.sift_down && i_req.right_ok && !(i_req.a_key < i_req.b_key);
        pick_key   = pick_right ? i_req.b_key : i_req.a_key;
        o_res.pick_right = pick_right;
        if (i_req.sift_down) begin
            // moving entry goes down while strictly greater than the chosen child
            o_res.move = i_req.e_key > pick_key;
        end else begin
            // moving entry goes up unless the parent is strictly less
            o_res.move = !(i_req.a_key < i_req.e_key);
        end
    end

endmodule

### src/min_heap_priority_queue_top.sv
// min-heap priority queue: entry memory, sift sequencer and output register
// depends on mhpq_pkg and mhpq_cmp
//
// Binary min-heap of CAPACITY entries, each a 32-bit unsigned key with a 16-bit
// tag. An insert word appends the entry and sifts it up (an equal key moves above
// its parent); an extract word returns the root key and tag, moves the last entry
// to the root and sifts it down, taking the left child unless the right key is
// not larger. One word is worked at a time: the input stalls from acceptance
// until the result is handed to the output register. Each heap level passes
// through S_RD, which reads the parent or both children from the entry memory
// (two registered read ports, one write port), and S_CMP, which runs the shared
// compare unit and writes back; full inserts and empty extracts skip the sift
// and go straight to S_DONE. The memory needs no clearing after reset, only
// entries below the count are ever used. The output register lets a new word
// be accepted while the previous result still waits to be taken.
module min_heap_priority_queue_top #(
    parameter int CAPACITY = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  mhpq_pkg::t_req  i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output mhpq_pkg::t_rsp  o_data
);
    import mhpq_pkg::*;

    // address, count and child index widths
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_RD   = 5'b00100,
        S_CMP  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // entry memory
    t_entry mem [CAPACITY];
    t_entry r_rd_a, r_rd_b;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_entry          wr_data;
    logic [AW-1:0]   rd_addr_a, rd_addr_b;

    // sequencer state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_pos, n_pos;
    t_entry          r_ent, n_ent;
    logic            r_down, n_down;
    logic            r_right_ok, n_right_ok;
    logic [1:0]      r_status, n_status;
    logic [KEY_W-1:0] r_min_key, n_min_key;
    logic [TAG_W-1:0] r_min_tag, n_min_tag;

    // output register
    logic            r_ovalid, n_ovalid;
    t_rsp            r_odata, n_odata;

    // index arithmetic
    logic [IW-1:0]   count_x, left_x, right_x;
    logic [CW-1:0]   cnt_m1;
    logic [AW-1:0]   parent;
    logic [CW+CNT_OUT-1:0] cnt_wide;
    logic            accept;

    t_cmp_req        cmp_req;
    t_cmp_res        cmp_res;

    mhpq_cmp u_cmp (
        .i_req (cmp_req),
        .o_res (cmp_res)
    );

    assign count_x  = {{(IW-CW){1'b0}}, r_count};
    assign left_x   = {1'b0, r_pos, 1'b1};
    assign right_x  = left_x + IW'(1);
    assign cnt_m1   = r_count - CW'(1);
    assign parent   = (r_pos - AW'(1)) >> 1;
    assign cnt_wide = {{CNT_OUT{1'b0}}, r_count};
    assign accept   = i_valid && (r_state == S_IDLE);

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_data   = r_odata;

    always_comb begin
        cmp_req.sift_down = r_down;
        cmp_req.right_ok  = r_right_ok;
        cmp_req.e_key     = r_ent.key;
        cmp_req.a_key     = r_rd_a.key;
        cmp_req.b_key     = r_rd_b.key;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_ent      = r_ent;
        n_down     = r_down;
        n_right_ok = r_right_ok;
        n_status   = r_status;
        n_min_key  = r_min_key;
        n_min_tag  = r_min_tag;
        n_ovalid   = r_ovalid && i_stall;
        n_odata    = r_odata;
        wr_en      = 1'b0;
        wr_addr    = r_pos;
        wr_data    = r_ent;
        // root and last entry by default, for the extract load
        rd_addr_a  = '0;
        rd_addr_b  = cnt_m1[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status  = ST_OK;
                    n_min_key = '0;
                    n_min_tag = '0;
                    if (i_data.req_type == REQ_INSERT) begin
                        if (count_x >= IW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            // hole at the new last slot, entry rides in r_ent
                            n_ent.key = i_data.new_key;
                            n_ent.tag = i_data.new_tag;
                            n_pos     = r_count[AW-1:0];
                            n_count   = r_count + CW'(1);
                            n_down    = 1'b0;
                            n_state   = S_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_count = cnt_m1;
                            n_pos   = '0;
                            n_down  = 1'b1;
                            n_state = S_LOAD;
                        end
                    end
                end
            end
            S_LOAD: begin
                // root goes out, last entry sifts down from a hole at the root
                n_min_key = r_rd_a.key;
                n_min_tag = r_rd_a.tag;
                n_ent     = r_rd_b;
                n_state   = S_RD;
            end
            S_RD: begin
                if (r_down) begin
                    if (left_x >= count_x) begin
                        wr_en   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        rd_addr_a  = left_x[AW-1:0];
                        rd_addr_b  = right_x[AW-1:0];
                        n_right_ok = right_x < count_x;
                        n_state    = S_CMP;
                    end
                end else begin
                    if (r_pos == '0) begin
                        wr_en   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        rd_addr_a = parent;
                        n_state   = S_CMP;
                    end
                end
            end
            S_CMP: begin
                wr_en = 1'b1;
                if (cmp_res.move) begin
                    // the parent or chosen child fills the hole, hole moves on
                    wr_data = cmp_res.pick_right ? r_rd_b : r_rd_a;
                    if (!r_down) begin
                        n_pos = parent;
                    end else if (cmp_res.pick_right) begin
                        n_pos = right_x[AW-1:0];
                    end else begin
                        n_pos = left_x[AW-1:0];
                    end
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid            = 1'b1;
                    n_odata.status      = r_status;
                    n_odata.min_key     = r_min_key;
                    n_odata.min_tag     = r_min_tag;
                    n_odata.entry_count = cnt_wide[CNT_OUT-1:0];
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_a <= mem[rd_addr_a];
        r_rd_b <= mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_ent      <= n_ent;
        r_down     <= n_down;
        r_right_ok <= n_right_ok;
        r_status   <= n_status;
        r_min_key  <= n_min_key;
        r_min_tag  <= n_min_tag;
        r_odata    <= n_odata;
    end

endmodule

### src/mhpq_chk.sv
// port-level checker for the min-heap priority queue, with its bind
// depends on mhpq_pkg; attaches to min_heap_priority_queue_top
module mhpq_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input mhpq_pkg::t_req i_data,
    input logic           o_valid,
    input logic           i_stall,
    input mhpq_pkg::t_rsp o_data
);
    import mhpq_pkg::*;

    // a word offered under stall holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> $stable(i_data))
        else $error("input word changed under stall");

    // a presented result holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result word changed under stall");

    // one word at a time: input stalls right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second word accepted while busy");

    // failed operations report no entry
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status != ST_OK) |-> (o_data.min_key == '0)
            && (o_data.min_tag == '0))
        else $error("failed operation reports an entry");

    // empty extract leaves no entries
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_EMPTY) |-> (o_data.entry_count == '0))
        else $error("empty report with nonzero count");

endmodule

bind min_heap_priority_queue_top mhpq_chk u_mhpq_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

### dv/mhpq_checker.sv
// response checker for the min-heap priority queue: mirrors the heap, compares each response
// depends on mhpq_pkg; instantiated by tb beside the block
module mhpq_checker #(
    parameter int CAPACITY = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_stall,
    input  mhpq_pkg::t_req i_req,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_stall,
    input  mhpq_pkg::t_rsp i_rsp,
    output int             o_errors,
    output int             o_pending
);
    import mhpq_pkg::*;

    logic [KEY_W-1:0] key_store [CAPACITY];
    logic [TAG_W-1:0] tag_store [CAPACITY];
    int unsigned      held;
    t_rsp             heap_rsp_q [$];

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [KEY_W-1:0] k;
        logic [TAG_W-1:0] t;
        k = key_store[a];
        t = tag_store[a];
        key_store[a] = key_store[b];
        tag_store[a] = tag_store[b];
        key_store[b] = k;
        tag_store[b] = t;
    endfunction

    // equal keys keep climbing
    function automatic void bubble_up(int unsigned pos);
        int unsigned par;
        while (pos > 0) begin
            par = (pos - 1) / 2;
            if (key_store[par] < key_store[pos])
                break;
            swap_slots(par, pos);
            pos = par;
        end
    endfunction

    // left child only when strictly smaller than the right one
    function automatic void bubble_down(int unsigned pos);
        int unsigned lc;
        int unsigned pick;
        forever begin
            lc = 2 * pos + 1;
            if (lc >= held)
                break;
            pick = lc;
            if (lc + 1 < held && !(key_store[lc] < key_store[lc + 1]))
                pick = lc + 1;
            if (key_store[pos] <= key_store[pick])
                break;
            swap_slots(pos, pick);
            pos = pick;
        end
    endfunction

    function automatic t_rsp apply_heap_op(t_req w);
        t_rsp r;
        r = '0;
        if (w.req_type == REQ_INSERT) begin
            if (held >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                key_store[held] = w.new_key;
                tag_store[held] = w.new_tag;
                held++;
                bubble_up(held - 1);
            end
        end else if (held == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.min_key = key_store[0];
            r.min_tag = tag_store[0];
            held--;
            key_store[0] = key_store[held];
            tag_store[0] = tag_store[held];
            bubble_down(0);
        end
        r.entry_count = CNT_OUT'(held);
        return r;
    endfunction

    task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            held = 0;
            heap_rsp_q.delete();
        end else begin
            // retire first: a response never belongs to a word taken at the same edge
            if (i_rsp_valid && !i_rsp_stall) begin
                if (heap_rsp_q.size() == 0) begin
                    $error("response word with no request outstanding");
                    o_errors++;
                end else begin
                    want = heap_rsp_q.pop_front();
                    check_field("status", KEY_W'(want.status), KEY_W'(i_rsp.status));
                    check_field("min_key", want.min_key, i_rsp.min_key);
                    check_field("min_tag", KEY_W'(want.min_tag), KEY_W'(i_rsp.min_tag));
                    check_field("entry_count", KEY_W'(want.entry_count),
                                KEY_W'(i_rsp.entry_count));
                end
            end
            if (i_req_valid && !i_req_stall)
                heap_rsp_q.push_back(apply_heap_op(i_req));
        end
        o_pending = heap_rsp_q.size();
    end

endmodule

### dv/tb.sv
// top of the min-heap priority queue bench: clock, reset, request stimulus and verdict
// depends on mhpq_pkg, min_heap_priority_queue_top and mhpq_checker
module tb;
    import mhpq_pkg::*;

    localparam int CAP       = 1024;
    localparam int CYCLE_CAP = 1000000;

    logic i_clk;
    logic i_rst_n   = 1'b0;
    logic drv_valid = 1'b0;
    logic drv_stall = 1'b0;
    t_req drv_data  = '0;
    logic o_stall;
    logic o_valid;
    t_rsp o_data;

    int fail_count;
    int owed;

    // idle percentages for each side, changed between phases
    int send_idle = 9;
    int recv_idle = 45;

    // running occupancy, used to steer fill and drain phases and to track peak occupancy
    int occ        = 0;
    int peak_occ   = 0;
    int n_insert   = 0;
    int n_extract  = 0;
    int full_hits  = 0;
    int empty_hits = 0;
    int cycles     = 0;

    min_heap_priority_queue_top #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(drv_valid),
        .o_stall(o_stall),
        .i_data (drv_data),
        .o_valid(o_valid),
        .i_stall(drv_stall),
        .o_data (o_data)
    );

    mhpq_checker #(
        .CAPACITY(CAP)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(drv_valid),
        .i_req_stall(o_stall),
        .i_req      (drv_data),
        .i_rsp_valid(o_valid),
        .i_rsp_stall(drv_stall),
        .i_rsp      (o_data),
        .o_errors   (fail_count),
        .o_pending  (owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        drv_stall <= ($urandom_range(99) < recv_idle);
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d responses outstanding", cycles, owed);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_req make_word(logic req, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
        t_req w;
        w.req_type = req;
        w.new_key  = k;
        w.new_tag  = t;
        return w;
    endfunction

    // mix of full-range keys, a narrow range that forces ties, the extremes and a 24-bit range
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(3))
            0: k = $urandom;
            1: k = $urandom_range(15);
            2: begin
                case ($urandom_range(3))
                    0: k = '0;
                    1: k = '1;
                    2: k = 32'h8000_0000;
                    default: k = 32'h7FFF_FFFF;
                endcase
            end
            default: k = $urandom_range(32'h00FF_FFFF);
        endcase
        return k;
    endfunction

    // extract words still carry random key and tag bits, which the block ignores
    function automatic t_req random_word(int insert_pct);
        logic req;
        req = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_EXTRACT;
        return make_word(req, pick_key(), TAG_W'($urandom));
    endfunction

    // called and returns at a falling edge; valid stays up until the word is taken
    task automatic send_word(t_req w);
        while ($urandom_range(99) < send_idle) begin
            drv_valid <= 1'b0;
            @(negedge i_clk);
        end
        drv_valid <= 1'b1;
        drv_data  <= w;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        // track occupancy the same way the heap does
        if (w.req_type == REQ_INSERT) begin
            n_insert++;
            if (occ < CAP) occ++;
            else full_hits++;
        end else begin
            n_extract++;
            if (occ > 0) occ--;
            else empty_hits++;
        end
        if (occ > peak_occ)
            peak_occ = occ;
        @(negedge i_clk);
    endtask

    // sender holds off until every response has come back
    task automatic wait_drained();
        drv_valid <= 1'b0;
        @(negedge i_clk);
        while (owed != 0)
            @(negedge i_clk);
    endtask

    initial begin
        // reset held low at the start, once
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty extract, key extremes, ties with the root and mid keys
        send_word(make_word(REQ_EXTRACT, '1, '1));
        send_word(make_word(REQ_INSERT, 32'h0000_0000, 16'hFFFF));
        send_word(make_word(REQ_INSERT, 32'hFFFF_FFFF, 16'h0000));
        send_word(make_word(REQ_INSERT, 32'h8000_0000, 16'h1234));
        send_word(make_word(REQ_INSERT, 32'h0001_0000, 16'hA5A5));
        send_word(make_word(REQ_INSERT, 32'h0000_0000, 16'h0001));
        send_word(make_word(REQ_INSERT, 32'h8000_0000, 16'h5A5A));
        send_word(make_word(REQ_INSERT, 32'hFFFF_FFFF, 16'h8000));
        send_word(make_word(REQ_INSERT, 32'h0001_0000, 16'h7FFF));
        // drain all eight, then one extract past empty
        repeat (9) send_word(make_word(REQ_EXTRACT, '0, '0));
        wait_drained();

        // mixed traffic, sender mostly busy, receiver stalls often
        repeat (40) send_word(random_word(60));
        wait_drained();

        // swap idling: fill to capacity, then hit the full case a few times
        send_idle = 45;
        recv_idle = 9;
        while (occ < CAP)
            send_word(random_word(98));
        repeat (5) send_word(make_word(REQ_INSERT, pick_key(), TAG_W'($urandom)));
        wait_drained();

        // no idling: drain to empty, extract past empty, then mixed traffic
        send_idle = 0;
        recv_idle = 0;
        while (occ > 0)
            send_word(random_word(2));
        repeat (3) send_word(make_word(REQ_EXTRACT, pick_key(), TAG_W'($urandom)));
        repeat (40) send_word(random_word(55));

        // let the last response land and anything stray show up
        wait_drained();
        repeat (30) @(negedge i_clk);

        $display("ran %0d inserts (%0d into a full heap) and %0d extracts (%0d from empty)",
                 n_insert, full_hits, n_extract, empty_hits);
        $display("peak occupancy %0d of %0d entries over %0d cycles", peak_occ, CAP, cycles);
        if (fail_count == 0 && owed == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
